>>> sv/w2s_pkg.sv
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared widths, register codes, stage indices and types for the
// world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int CLIP_W    = SHIFT_W + 3;
  localparam int WMAG_W    = CLIP_W - 1;
  localparam int DIV_W     = CLIP_W;
  localparam int LO_W      = 32;
  localparam int W_HI_W    = WMAG_W - LO_W;
  localparam int M_HI_W    = CLIP_W - LO_W;
  localparam int GEO_W     = 16;
  localparam int K_W       = GEO_W + 2;
  localparam int NUM_W     = CLIP_W + K_W;
  localparam int PIX_W     = 16;
  localparam int QUOT_W    = PIX_W;
  localparam int CFG_W     = 64;

  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW = 3'd6;

  localparam int N_CH   = 3;
  localparam int CH_X   = 0;
  localparam int CH_Y   = 1;
  localparam int CH_W   = 2;
  localparam int N_TERM = 3;

  // top-level stages
  localparam int PROD_STG = 0;
  localparam int SUM_STG  = 1;
  localparam int PREP_STG = 2;
  localparam int TOP_STG  = 3;

  // pixel pipe stages (local numbering)
  localparam int PJ_PP   = 0;
  localparam int PJ_ADD  = 1;
  localparam int PJ_NUM  = 2;
  localparam int PJ_OVF  = 3;
  localparam int PJ_DIV0 = 4;
  localparam int PIX_STG = PJ_DIV0 + QUOT_W + 1;
  localparam int PJ_FIN  = PIX_STG - 1;

  localparam int N_STG = TOP_STG + PIX_STG;

  localparam logic signed [COORD_W-1:0] W_SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] W_SAT_MIN = 32'sh8000_0000;
  localparam logic [PIX_W-1:0]          PIX_MAX   = 16'h7FFF;
  localparam logic [PIX_W-1:0]          PIX_MIN   = 16'h8000;

  typedef struct packed {
    logic              vis;
    logic              neg;
    logic [CLIP_W-1:0] mag;
    logic [WMAG_W-1:0] w;
    logic [K_W-1:0]    k;
    logic [GEO_W-1:0]  size;
  } pix_in_t;

endpackage

>>> sv/world_to_screen_projection_unit.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Fixed-point perspective projection and viewport mapping of 3D points.
// Pipeline stages, input to result transaction: 3 clip stages, 21 pixel.
// Throughput: one transaction per cycle while the output is not stalled; every stage, each divide step too.
// Stalls ripple back only through occupied stages; bubbles are absorbed.
// Reset clears stage valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [w2s_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [w2s_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [w2s_pkg::COORD_W-1:0]  in_point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [w2s_pkg::PIX_W-1:0]    out_screen_x,
  output logic signed [w2s_pkg::PIX_W-1:0]    out_screen_y,
  output logic signed [w2s_pkg::COORD_W-1:0]  out_clip_w,
  output logic                                out_visible,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [w2s_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [w2s_pkg::CFG_W-1:0]           cfg_data
);

  logic [w2s_pkg::CFG_W-1:0] cfg_r [w2s_pkg::NUM_REGS];

  logic [w2s_pkg::N_STG-1:0] v_r;
  logic [w2s_pkg::N_STG-1:0] en;

  logic signed [w2s_pkg::COORD_W-1:0] pt [w2s_pkg::N_TERM];
  logic signed [w2s_pkg::COORD_W-1:0] cf [w2s_pkg::N_CH][w2s_pkg::N_TERM];
  logic signed [w2s_pkg::COORD_W-1:0] tr [w2s_pkg::N_CH];
  logic [w2s_pkg::CFG_W-1:0]          lo [w2s_pkg::N_CH];
  logic [w2s_pkg::CFG_W-1:0]          hi [w2s_pkg::N_CH];

  logic signed [w2s_pkg::PROD_W-1:0] prod_r  [w2s_pkg::N_CH][w2s_pkg::N_TERM];
  logic signed [w2s_pkg::CLIP_W-1:0] sum_r   [w2s_pkg::N_CH];
  logic signed [w2s_pkg::CLIP_W-1:0] sum_nxt [w2s_pkg::N_CH];

  logic [w2s_pkg::GEO_W-1:0] vp_left;
  logic [w2s_pkg::GEO_W-1:0] vp_top;
  logic [w2s_pkg::GEO_W-1:0] vp_width;
  logic [w2s_pkg::GEO_W-1:0] vp_height;

  w2s_pkg::pix_in_t pin_x_nxt;
  w2s_pkg::pix_in_t pin_y_nxt;
  w2s_pkg::pix_in_t pin_x_r;
  w2s_pkg::pix_in_t pin_y_r;

  logic signed [w2s_pkg::COORD_W-1:0] wsat_nxt;
  logic                               vis_nxt;
  logic [w2s_pkg::COORD_W-1:0]        wsat_r [w2s_pkg::PREP_STG:w2s_pkg::N_STG-1];
  logic                               vis_r  [w2s_pkg::PREP_STG:w2s_pkg::N_STG-1];

  logic [w2s_pkg::PIX_W-1:0] pix_x;
  logic [w2s_pkg::PIX_W-1:0] pix_y;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < w2s_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < w2s_pkg::CFG_IDX_W'(w2s_pkg::NUM_REGS))) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    lo[w2s_pkg::CH_X] = cfg_r[w2s_pkg::REG_X_LO];
    hi[w2s_pkg::CH_X] = cfg_r[w2s_pkg::REG_X_HI];
    lo[w2s_pkg::CH_Y] = cfg_r[w2s_pkg::REG_Y_LO];
    hi[w2s_pkg::CH_Y] = cfg_r[w2s_pkg::REG_Y_HI];
    lo[w2s_pkg::CH_W] = cfg_r[w2s_pkg::REG_W_LO];
    hi[w2s_pkg::CH_W] = cfg_r[w2s_pkg::REG_W_HI];
    for (int c = 0; c < w2s_pkg::N_CH; c++) begin
      cf[c][0] = lo[c][w2s_pkg::COORD_W-1:0];
      cf[c][1] = lo[c][w2s_pkg::CFG_W-1:w2s_pkg::COORD_W];
      cf[c][2] = hi[c][w2s_pkg::COORD_W-1:0];
      tr[c]    = hi[c][w2s_pkg::CFG_W-1:w2s_pkg::COORD_W];
    end
  end

  assign vp_left   = cfg_r[w2s_pkg::REG_VIEW][15:0];
  assign vp_top    = cfg_r[w2s_pkg::REG_VIEW][31:16];
  assign vp_width  = cfg_r[w2s_pkg::REG_VIEW][47:32];
  assign vp_height = cfg_r[w2s_pkg::REG_VIEW][63:48];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  // stage enables: a stage loads unless it and every stage after it are full and the output is stalled
  for (genvar k = 0; k < w2s_pkg::N_STG; k++) begin : g_en
    assign en[k] = !(&v_r[w2s_pkg::N_STG-1:k]) || !out_stall;
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < w2s_pkg::N_STG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // clip sums: floor-shifted products plus translation
  always_comb begin
    for (int c = 0; c < w2s_pkg::N_CH; c++) begin
      sum_nxt[c] = w2s_pkg::CLIP_W'(prod_r[c][0] >>> w2s_pkg::FRAC_BITS)
                 + w2s_pkg::CLIP_W'(prod_r[c][1] >>> w2s_pkg::FRAC_BITS)
                 + w2s_pkg::CLIP_W'(prod_r[c][2] >>> w2s_pkg::FRAC_BITS)
                 + w2s_pkg::CLIP_W'(tr[c]);
    end
  end

  // visibility, saturated w and per-axis operands
  always_comb begin
    logic signed [w2s_pkg::CLIP_W-1:0] w;
    logic signed [w2s_pkg::CLIP_W-1:0] cx;
    logic signed [w2s_pkg::CLIP_W-1:0] cy;
    w  = sum_r[w2s_pkg::CH_W];
    cx = sum_r[w2s_pkg::CH_X];
    cy = sum_r[w2s_pkg::CH_Y];
    vis_nxt = !w[w2s_pkg::CLIP_W-1] && (w != '0);
    if (w > w2s_pkg::CLIP_W'(w2s_pkg::W_SAT_MAX)) begin
      wsat_nxt = w2s_pkg::W_SAT_MAX;
    end else if (w < w2s_pkg::CLIP_W'(w2s_pkg::W_SAT_MIN)) begin
      wsat_nxt = w2s_pkg::W_SAT_MIN;
    end else begin
      wsat_nxt = w[w2s_pkg::COORD_W-1:0];
    end

    pin_x_nxt.vis  = vis_nxt;
    pin_x_nxt.neg  = cx[w2s_pkg::CLIP_W-1];
    pin_x_nxt.mag  = cx[w2s_pkg::CLIP_W-1] ? -cx : cx;
    pin_x_nxt.w    = w[w2s_pkg::WMAG_W-1:0];
    pin_x_nxt.k    = {1'b0, vp_left, 1'b0} + {2'b00, vp_width};
    pin_x_nxt.size = vp_width;

    // y is flipped: the signed term is -cy
    pin_y_nxt.vis  = vis_nxt;
    pin_y_nxt.neg  = !cy[w2s_pkg::CLIP_W-1] && (cy != '0);
    pin_y_nxt.mag  = cy[w2s_pkg::CLIP_W-1] ? -cy : cy;
    pin_y_nxt.w    = w[w2s_pkg::WMAG_W-1:0];
    pin_y_nxt.k    = {1'b0, vp_top, 1'b0} + {2'b00, vp_height};
    pin_y_nxt.size = vp_height;
  end

  always_ff @(posedge clk) begin
    if (en[w2s_pkg::PROD_STG]) begin
      for (int c = 0; c < w2s_pkg::N_CH; c++) begin
        for (int t = 0; t < w2s_pkg::N_TERM; t++) begin
          prod_r[c][t] <= w2s_pkg::PROD_W'(cf[c][t]) * w2s_pkg::PROD_W'(pt[t]);
        end
      end
    end
    if (en[w2s_pkg::SUM_STG]) begin
      for (int c = 0; c < w2s_pkg::N_CH; c++) begin
        sum_r[c] <= sum_nxt[c];
      end
    end
    if (en[w2s_pkg::PREP_STG]) begin
      pin_x_r                   <= pin_x_nxt;
      pin_y_r                   <= pin_y_nxt;
      wsat_r[w2s_pkg::PREP_STG] <= wsat_nxt;
      vis_r[w2s_pkg::PREP_STG]  <= vis_nxt;
    end
    for (int k = w2s_pkg::TOP_STG; k < w2s_pkg::N_STG; k++) begin
      if (en[k]) begin
        wsat_r[k] <= wsat_r[k-1];
        vis_r[k]  <= vis_r[k-1];
      end
    end
  end

  w2s_pix_pipe u_pix_x (
    .clk (clk),
    .en  (en[w2s_pkg::N_STG-1:w2s_pkg::TOP_STG]),
    .pin (pin_x_r),
    .pix (pix_x)
  );

  w2s_pix_pipe u_pix_y (
    .clk (clk),
    .en  (en[w2s_pkg::N_STG-1:w2s_pkg::TOP_STG]),
    .pin (pin_y_r),
    .pix (pix_y)
  );

  assign out_valid    = v_r[w2s_pkg::N_STG-1];
  assign out_screen_x = pix_x;
  assign out_screen_y = pix_y;
  assign out_clip_w   = wsat_r[w2s_pkg::N_STG-1];
  assign out_visible  = vis_r[w2s_pkg::N_STG-1];

  // a hidden point carries a zero pixel position
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> (out_screen_x == '0) && (out_screen_y == '0))
    else $error("hidden point with nonzero pixel position");

  // visibility and saturated w must agree
  a_vis_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> !out_clip_w[w2s_pkg::COORD_W-1] && (out_clip_w != '0))
    else $error("visible point with non-positive w");

  // back-pressure only when every stage is occupied and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && (&v_r))
    else $error("input stalled with room in the pipeline");

  // an unaccepted result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clip_w) && $stable(out_screen_x))
    else $error("stalled result lost or changed");

endmodule

>>> sv/w2s_pix_pipe.sv
// ----------------------------------------------------------------------------
// w2s_pix_pipe
// One viewport coordinate: forms (2*origin+size)*w +/- |v|*size, then a
// restoring divide by 2w, one quotient bit per stage, truncated and saturated.
// ----------------------------------------------------------------------------
module w2s_pix_pipe (
  input  logic                          clk,
  input  logic [w2s_pkg::PIX_STG-1:0]   en,
  input  w2s_pkg::pix_in_t              pin,
  output logic [w2s_pkg::PIX_W-1:0]     pix
);

  logic [w2s_pkg::LO_W+w2s_pkg::K_W-1:0]     bl_r;
  logic [w2s_pkg::W_HI_W+w2s_pkg::K_W-1:0]   bh_r;
  logic [w2s_pkg::LO_W+w2s_pkg::GEO_W-1:0]   tl_r;
  logic [w2s_pkg::M_HI_W+w2s_pkg::GEO_W-1:0] th_r;

  logic [w2s_pkg::NUM_W-1:0] base_r;
  logic [w2s_pkg::NUM_W-1:0] term_r;
  logic [w2s_pkg::NUM_W-1:0] num_r;

  logic [w2s_pkg::DIV_W-1:0] d_r   [0:w2s_pkg::PJ_FIN-2];
  logic                      vis_r [0:w2s_pkg::PJ_FIN-1];
  logic                      neg_r [0:w2s_pkg::PJ_FIN-1];

  logic [w2s_pkg::NUM_W-1:0]  rem_r [0:w2s_pkg::QUOT_W-1];
  logic [w2s_pkg::QUOT_W-1:0] q_r   [0:w2s_pkg::QUOT_W-1];
  logic                       ovf_r [0:w2s_pkg::QUOT_W];

  logic [w2s_pkg::NUM_W-1:0]  sum_nxt;
  logic [w2s_pkg::NUM_W-1:0]  num_nxt;
  logic                       lt;
  logic                       ovf_nxt;
  logic [w2s_pkg::NUM_W-1:0]  dsh     [0:w2s_pkg::QUOT_W-1];
  logic                       ge      [0:w2s_pkg::QUOT_W-1];
  logic [w2s_pkg::NUM_W-1:0]  rem_nxt [0:w2s_pkg::QUOT_W-1];
  logic [w2s_pkg::QUOT_W-1:0] q_nxt   [0:w2s_pkg::QUOT_W-1];
  logic [w2s_pkg::PIX_W-1:0]  pix_nxt;
  logic [w2s_pkg::PIX_W-1:0]  pix_r;

  // signed numerator magnitude
  always_comb begin
    sum_nxt = base_r + term_r;
    lt      = base_r < term_r;
    if (!neg_r[w2s_pkg::PJ_ADD]) begin
      num_nxt = sum_nxt;
    end else if (lt) begin
      num_nxt = term_r - base_r;
    end else begin
      num_nxt = base_r - term_r;
    end
  end

  assign ovf_nxt = num_r >= (w2s_pkg::NUM_W'(d_r[w2s_pkg::PJ_NUM]) << w2s_pkg::QUOT_W);

  // one quotient bit per stage
  always_comb begin
    logic [w2s_pkg::QUOT_W-1:0] qp;
    for (int s = 0; s < w2s_pkg::QUOT_W; s++) begin
      if (s == 0) begin
        qp = '0;
      end else begin
        qp = q_r[s-1];
      end
      dsh[s]     = w2s_pkg::NUM_W'(d_r[w2s_pkg::PJ_DIV0+s-1]) << (w2s_pkg::QUOT_W-1-s);
      ge[s]      = rem_r[s] >= dsh[s];
      rem_nxt[s] = ge[s] ? rem_r[s] - dsh[s] : rem_r[s];
      q_nxt[s]   = qp | (w2s_pkg::QUOT_W'(ge[s]) << (w2s_pkg::QUOT_W-1-s));
    end
  end

  always_comb begin
    logic [w2s_pkg::QUOT_W-1:0] qf;
    logic                       ovff;
    qf   = q_r[w2s_pkg::QUOT_W-1];
    ovff = ovf_r[w2s_pkg::QUOT_W];
    if (!vis_r[w2s_pkg::PJ_FIN-1]) begin
      pix_nxt = '0;
    end else if (neg_r[w2s_pkg::PJ_FIN-1]) begin
      if (ovff || (qf[w2s_pkg::QUOT_W-1] && (qf[w2s_pkg::QUOT_W-2:0] != '0))) begin
        pix_nxt = w2s_pkg::PIX_MIN;
      end else begin
        pix_nxt = w2s_pkg::PIX_W'(-qf);
      end
    end else begin
      if (ovff || qf[w2s_pkg::QUOT_W-1]) begin
        pix_nxt = w2s_pkg::PIX_MAX;
      end else begin
        pix_nxt = w2s_pkg::PIX_W'(qf);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[w2s_pkg::PJ_PP]) begin
      bl_r     <= (w2s_pkg::LO_W+w2s_pkg::K_W)'(pin.w[w2s_pkg::LO_W-1:0])
                * (w2s_pkg::LO_W+w2s_pkg::K_W)'(pin.k);
      bh_r     <= (w2s_pkg::W_HI_W+w2s_pkg::K_W)'(pin.w[w2s_pkg::WMAG_W-1:w2s_pkg::LO_W])
                * (w2s_pkg::W_HI_W+w2s_pkg::K_W)'(pin.k);
      tl_r     <= (w2s_pkg::LO_W+w2s_pkg::GEO_W)'(pin.mag[w2s_pkg::LO_W-1:0])
                * (w2s_pkg::LO_W+w2s_pkg::GEO_W)'(pin.size);
      th_r     <= (w2s_pkg::M_HI_W+w2s_pkg::GEO_W)'(pin.mag[w2s_pkg::CLIP_W-1:w2s_pkg::LO_W])
                * (w2s_pkg::M_HI_W+w2s_pkg::GEO_W)'(pin.size);
      d_r[0]   <= {pin.w, 1'b0};
      vis_r[0] <= pin.vis;
      neg_r[0] <= pin.neg;
    end
    if (en[w2s_pkg::PJ_ADD]) begin
      base_r <= (w2s_pkg::NUM_W'(bh_r) << w2s_pkg::LO_W) + w2s_pkg::NUM_W'(bl_r);
      term_r <= (w2s_pkg::NUM_W'(th_r) << w2s_pkg::LO_W) + w2s_pkg::NUM_W'(tl_r);
    end
    if (en[w2s_pkg::PJ_NUM]) begin
      num_r <= num_nxt;
    end
    for (int j = 1; j < w2s_pkg::PJ_FIN; j++) begin
      if (en[j]) begin
        vis_r[j] <= vis_r[j-1];
        if (j == w2s_pkg::PJ_NUM) begin
          neg_r[j] <= neg_r[j-1] & lt;
        end else begin
          neg_r[j] <= neg_r[j-1];
        end
      end
    end
    for (int j = 1; j < w2s_pkg::PJ_FIN - 1; j++) begin
      if (en[j]) begin
        d_r[j] <= d_r[j-1];
      end
    end
    if (en[w2s_pkg::PJ_OVF]) begin
      rem_r[0] <= num_r;
      ovf_r[0] <= ovf_nxt;
    end
    for (int s = 0; s < w2s_pkg::QUOT_W; s++) begin
      if (en[w2s_pkg::PJ_DIV0+s]) begin
        q_r[s]     <= q_nxt[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
    for (int s = 0; s < w2s_pkg::QUOT_W - 1; s++) begin
      if (en[w2s_pkg::PJ_DIV0+s]) begin
        rem_r[s+1] <= rem_nxt[s];
      end
    end
    if (en[w2s_pkg::PJ_FIN]) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule
